/* rtl/sucs_pkg.sv */
// Package for the sorted unique coordinate set.
// Holds the operation codes, sequencer states, cell control word and default capacity.
// No dependencies.
package sucs_pkg;

    localparam int DEF_CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic cmp;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

/* rtl/sucs_cell.sv */
// One cell of the sorted chain: holds one entry, its valid bit and its compare flags.
// Depends on sucs_pkg.
module sucs_cell import sucs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] key,
    input  logic signed [31:0] left_entry,
    input  logic               left_valid,
    input  logic               left_le,
    output logic signed [31:0] entry,
    output logic               valid,
    output logic               le,
    output logic               eq
);

    logic signed [31:0] entry_reg, entry_next;
    logic               valid_reg, valid_next;
    logic               le_reg, le_next;
    logic               eq_reg, eq_next;

    always_comb begin
        le_next    = le_reg;
        eq_next    = eq_reg;
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctrl.cmp) begin
            le_next = valid_reg && (entry_reg <= key);
            eq_next = valid_reg && (entry_reg == key);
        end
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift && !le_reg) begin
            entry_next = left_le ? key : left_entry;
            valid_next = valid_reg || left_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            le_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            le_reg    <= le_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign le    = le_reg;
    assign eq    = eq_reg;

endmodule

/* rtl/sorted_unique_coordinate_set.sv */
// Sorted unique coordinate set: keeps up to CAPACITY signed 32-bit values in ascending
// order in a chain of cells, each holding one entry. An item passes through the idle state,
// in which the word is accepted and captured, a compare state, in which every cell compares
// its entry with the key in parallel, and an update state, which shifts the chain on insert,
// empties it on clear and registers the result. A new word is taken only once the previous
// item has left the update state; the update state holds for as long as the previous
// result waits unread in the output register.
// Depends on sucs_pkg and sucs_cell.
module sorted_unique_coordinate_set import sucs_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CNT_W-1:0]   m_position,
    output logic               m_found,
    output logic [CNT_W-1:0]   m_entry_total,
    output logic               m_dropped
);

    state_t             state_reg, state_next;
    logic [1:0]         op_reg;
    logic signed [31:0] key_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]   m_position_reg, m_position_next;
    logic               m_found_reg, m_found_next;
    logic [CNT_W-1:0]   m_entry_total_reg, m_entry_total_next;
    logic               m_dropped_reg, m_dropped_next;

    cell_ctrl_t                ctrl;
    logic signed [31:0]        entry [CAPACITY];
    logic [CAPACITY-1:0]       valid;
    logic [CAPACITY-1:0]       le;
    logic [CAPACITY-1:0]       eq;
    logic [CAPACITY-1:0]       bnd;
    logic [CNT_W-1:0]          ub;
    logic                      any_eq;
    logic                      full;
    logic                      upd_go;
    logic                      do_ins;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                sucs_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .key        (key_reg),
                    .left_entry (key_reg),
                    .left_valid (1'b1),
                    .left_le    (1'b1),
                    .entry      (entry[gi]),
                    .valid      (valid[gi]),
                    .le         (le[gi]),
                    .eq         (eq[gi])
                );
            end else begin : g_body
                sucs_cell u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .key        (key_reg),
                    .left_entry (entry[gi-1]),
                    .left_valid (valid[gi-1]),
                    .left_le    (le[gi-1]),
                    .entry      (entry[gi]),
                    .valid      (valid[gi]),
                    .le         (le[gi]),
                    .eq         (eq[gi])
                );
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign bnd[gi] = le[gi];
            end else begin : g_mid
                assign bnd[gi] = le[gi] && !le[gi+1];
            end
        end
    endgenerate

    always_comb begin
        ub = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ub = ub | (bnd[i] ? CNT_W'(i + 1) : CNT_W'(0));
        end
    end

    assign any_eq = |eq;
    assign full   = (cnt_reg == CNT_W'(CAPACITY));
    assign upd_go = (state_reg == ST_UPD) && (!m_valid_reg || m_ready);
    assign do_ins = upd_go && (op_reg == OP_INSERT) && !any_eq && !full;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (upd_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        ctrl.cmp   = (state_reg == ST_CMP);
        ctrl.shift = do_ins;
        ctrl.clear = upd_go && (op_reg == OP_CLEAR);
    end

    always_comb begin
        cnt_next           = cnt_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_position_next    = m_position_reg;
        m_found_next       = m_found_reg;
        m_entry_total_next = m_entry_total_reg;
        m_dropped_next     = m_dropped_reg;
        if (upd_go) begin
            m_valid_next    = 1'b1;
            m_position_next = '0;
            m_found_next    = 1'b0;
            m_dropped_next  = 1'b0;
            if (op_reg inside {OP_INSERT, OP_QUERY}) begin
                m_position_next = ub;
                m_found_next    = any_eq;
                if (op_reg == OP_INSERT && !any_eq) begin
                    if (full) begin
                        m_dropped_next = 1'b1;
                    end else begin
                        m_position_next = ub + CNT_W'(1);
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
            end else if (op_reg == OP_CLEAR) begin
                cnt_next = '0;
            end
            m_entry_total_next = cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            key_reg <= s_value;
        end
        m_position_reg    <= m_position_next;
        m_found_reg       <= m_found_next;
        m_entry_total_reg <= m_entry_total_next;
        m_dropped_reg     <= m_dropped_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_position    = m_position_reg;
    assign m_found       = m_found_reg;
    assign m_entry_total = m_entry_total_reg;
    assign m_dropped     = m_dropped_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_cnt_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid) == int'(cnt_reg))
        else $error("valid cells disagree with entry count");

    a_bnd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> $onehot0(bnd))
        else $error("compare flags not a thermometer code");

    a_upd_result: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("update cycle gave no result");

    a_found_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_found_reg && m_dropped_reg))
        else $error("result both found and dropped");

endmodule
